@@ src/bfm_pkg.sv @@
// bfm_pkg: shared types, fault codes and constants for the brake fault monitor.
// No dependencies; used by the interfaces, the classifier and the top level.
`default_nettype none
package bfm_pkg;

  localparam int unsigned WHEELS = 4;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BUS_TIMEOUT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_TIME = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY     = 2'd2;

  localparam logic [15:0] BUS_TIMEOUT_RST  = 16'd100;
  localparam logic [15:0] CONFIRM_TIME_RST = 16'd200;
  localparam logic [15:0] RECOVERY_RST     = 16'd500;

  // Plausibility limits
  localparam logic [15:0] WHEEL_MAX_KPH    = 16'd300;
  localparam logic [15:0] MISMATCH_MIN_KPH = 16'd10;
  localparam logic [15:0] STUCK_MIN_KPH    = 16'd15;
  localparam logic [15:0] UNDER_CMD_MIN    = 16'd2000;
  localparam logic [16:0] UNDER_MARGIN     = 17'd1500;
  localparam logic [15:0] HIGH_FB_MIN      = 16'd1000;
  localparam logic [15:0] LOW_CMD_MIN      = 16'd1000;
  localparam logic [15:0] LOW_FB_MAX       = 16'd100;
  localparam logic [7:0]  REQUEST_MAX_PCT  = 8'd100;

  typedef enum logic [3:0] {
    F_NONE     = 4'd0,
    F_TIMEOUT  = 4'd1,
    F_RANGE    = 4'd2,
    F_STUCK    = 4'd3,
    F_MISMATCH = 4'd4,
    F_UNDER    = 4'd5,
    F_HIGH     = 4'd6,
    F_LOW      = 4'd7,
    F_INVALID  = 4'd8,
    F_CORRUPT  = 4'd9
  } fault_t;

  localparam logic [1:0] SEV_NONE     = 2'd0;
  localparam logic [1:0] SEV_DEGRADED = 2'd1;
  localparam logic [1:0] SEV_FAILSAFE = 2'd2;

  typedef logic [15:0] wheel_arr_t [WHEELS];

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] last_rx_ms;
    logic        has_message;
    logic [15:0] pressure_command;
    logic        signal_ok;
    logic [7:0]  request_pct;
    logic [15:0] vehicle_kph;
    logic [15:0] pressure_kpa;
    logic [15:0] wheel0_kph;
    logic [15:0] wheel1_kph;
    logic [15:0] wheel2_kph;
    logic [15:0] wheel3_kph;
  } sample_t;

  typedef struct packed {
    logic [3:0] active_fault;
    logic       fault_confirmed;
    logic       fault_latched;
    logic [1:0] severity_level;
  } result_t;

  typedef struct packed {
    logic [15:0] bus_timeout_ms;
    logic        history_valid;
  } class_ctl_t;

endpackage
`default_nettype wire

@@ src/bfm_sample_if.sv @@
// bfm_sample_if: valid/ready channel carrying one diagnostic sample per beat.
// Depends on bfm_pkg for the payload type.
`default_nettype none
interface bfm_sample_if;
  logic             valid;
  logic             ready;
  bfm_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/bfm_result_if.sv @@
// bfm_result_if: valid/ready channel carrying one fault status per beat.
// Depends on bfm_pkg for the payload type.
`default_nettype none
interface bfm_result_if;
  logic             valid;
  logic             ready;
  bfm_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/bfm_classify.sv @@
// bfm_classify: picks the single highest-priority fault for one sample.
// Pure combinational; depends on bfm_pkg.
`default_nettype none
module bfm_classify (
  input  wire bfm_pkg::sample_t   smp,
  input  wire bfm_pkg::class_ctl_t ctl,
  input  wire bfm_pkg::wheel_arr_t prior,
  output bfm_pkg::fault_t          code
);

  bfm_pkg::wheel_arr_t wh;
  logic [31:0] gap;
  logic [17:0] total;
  logic [2:0]  same;
  logic        range_bad;
  logic        mismatch;
  logic        stuck;
  logic [16:0] fb_margin;

  always_comb begin
    wh[0] = smp.wheel0_kph;
    wh[1] = smp.wheel1_kph;
    wh[2] = smp.wheel2_kph;
    wh[3] = smp.wheel3_kph;
  end

  always_comb begin
    range_bad = 1'b0;
    total     = '0;
    same      = '0;
    for (int k = 0; k < bfm_pkg::WHEELS; k++) begin
      range_bad = range_bad | (wh[k] > bfm_pkg::WHEEL_MAX_KPH);
      total     = total + 18'(wh[k]);
      same      = same + 3'(ctl.history_valid && (wh[k] == prior[k]));
    end
  end

  assign gap       = smp.now_ms - smp.last_rx_ms;
  // average floor(total/4) against floor(speed/2)
  assign mismatch  = (smp.vehicle_kph > bfm_pkg::MISMATCH_MIN_KPH) &&
                     ({2'b00, total[17:2]} < {3'b000, smp.vehicle_kph[15:1]});
  assign stuck     = ctl.history_valid && (smp.vehicle_kph > bfm_pkg::STUCK_MIN_KPH) &&
                     (same == 3'd1);
  assign fb_margin = {1'b0, smp.pressure_kpa} + bfm_pkg::UNDER_MARGIN;

  always_comb begin
    if (!smp.has_message || (gap > {16'h0000, ctl.bus_timeout_ms})) begin
      code = bfm_pkg::F_TIMEOUT;
    end else if (!smp.signal_ok) begin
      code = bfm_pkg::F_CORRUPT;
    end else if (smp.request_pct > bfm_pkg::REQUEST_MAX_PCT) begin
      code = bfm_pkg::F_INVALID;
    end else if (range_bad) begin
      code = bfm_pkg::F_RANGE;
    end else if (mismatch) begin
      code = bfm_pkg::F_MISMATCH;
    end else if (stuck) begin
      code = bfm_pkg::F_STUCK;
    end else if ((smp.pressure_command > bfm_pkg::UNDER_CMD_MIN) &&
                 (fb_margin < {1'b0, smp.pressure_command})) begin
      code = bfm_pkg::F_UNDER;
    end else if ((smp.pressure_command == 16'd0) &&
                 (smp.pressure_kpa > bfm_pkg::HIGH_FB_MIN)) begin
      code = bfm_pkg::F_HIGH;
    end else if ((smp.pressure_command > bfm_pkg::LOW_CMD_MIN) &&
                 (smp.pressure_kpa < bfm_pkg::LOW_FB_MAX)) begin
      code = bfm_pkg::F_LOW;
    end else begin
      code = bfm_pkg::F_NONE;
    end
  end

endmodule
`default_nettype wire

@@ src/brake_fault_monitor.sv @@
// brake_fault_monitor: confirms, latches and recovers brake bus faults per sample.
// Each sample passes the input register (s1), then the result register; one sample
// per cycle while the result sink keeps up, as the fault state updates once per sample.
// Reset (rst, synchronous, active high): no fault, empty history, timers cleared,
// registers at 100 / 200 / 500 ms. Depends on bfm_pkg, the two channel
// interfaces and bfm_classify.
`default_nettype none
module brake_fault_monitor (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_write,
  input  wire [bfm_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  wire [bfm_pkg::CFG_DATA_W-1:0]          cfg_data,
  bfm_sample_if.sink                             sample,
  bfm_result_if.source                           result
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] bus_timeout_ms;
  logic [15:0] confirm_time_ms;
  logic [15:0] recovery_time_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_timeout_ms   <= bfm_pkg::BUS_TIMEOUT_RST;
      confirm_time_ms  <= bfm_pkg::CONFIRM_TIME_RST;
      recovery_time_ms <= bfm_pkg::RECOVERY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bfm_pkg::REG_BUS_TIMEOUT:  bus_timeout_ms   <= cfg_data;
        bfm_pkg::REG_CONFIRM_TIME: confirm_time_ms  <= cfg_data;
        bfm_pkg::REG_RECOVERY:     recovery_time_ms <= cfg_data;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: input register (s1) feeds the result register.
  // s1 drains whenever the result register is empty or its beat is taken,
  // so a new sample can be taken every cycle while the sink keeps up.
  // ---------------------------------------------------------------------------
  logic             s1_valid;
  bfm_pkg::sample_t s1;
  logic             res_valid;
  bfm_pkg::result_t res;
  logic             out_free;
  logic             s1_go;
  logic             take_in;

  assign out_free     = !res_valid || result.ready;
  assign s1_go        = s1_valid && out_free;
  assign sample.ready = !s1_valid || out_free;
  assign take_in      = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1 <= sample.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Fault state
  // ---------------------------------------------------------------------------
  bfm_pkg::fault_t     fault_code, fault_code_next;
  logic [31:0]         fault_start, fault_start_next;
  logic                confirmed_flag, confirmed_flag_next;
  logic [31:0]         recovery_start, recovery_start_next;
  logic                latched_flag, latched_flag_next;
  logic                history_valid;
  bfm_pkg::wheel_arr_t prior_wheels;

  bfm_pkg::fault_t     code;
  bfm_pkg::class_ctl_t ctl;
  logic [31:0]         since_fault;
  logic [31:0]         rec_base;
  logic [31:0]         since_rec;
  logic [1:0]          sev;

  assign ctl.bus_timeout_ms = bus_timeout_ms;
  assign ctl.history_valid  = history_valid;

  bfm_classify u_classify (
    .smp   (s1),
    .ctl   (ctl),
    .prior (prior_wheels),
    .code  (code)
  );

  // a new fault restarts its timer at now, so elapsed time is zero
  assign since_fault = (code != fault_code) ? 32'd0 : (s1.now_ms - fault_start);
  // a zero recovery start counts as not started
  assign rec_base    = (recovery_start == 32'd0) ? s1.now_ms : recovery_start;
  assign since_rec   = s1.now_ms - rec_base;

  always_comb begin
    fault_code_next     = fault_code;
    fault_start_next    = fault_start;
    confirmed_flag_next = confirmed_flag;
    recovery_start_next = recovery_start;
    if (code != bfm_pkg::F_NONE) begin
      if (code != fault_code) begin
        fault_code_next     = code;
        fault_start_next    = s1.now_ms;
        confirmed_flag_next = 1'b0;
      end
      if ((since_fault >= {16'h0000, confirm_time_ms}) || (code == bfm_pkg::F_TIMEOUT)) begin
        confirmed_flag_next = 1'b1;
      end
      recovery_start_next = 32'd0;
    end else if ((fault_code != bfm_pkg::F_NONE) && !latched_flag) begin
      recovery_start_next = rec_base;
      if (since_rec >= {16'h0000, recovery_time_ms}) begin
        fault_code_next     = bfm_pkg::F_NONE;
        confirmed_flag_next = 1'b0;
      end
    end
    latched_flag_next = (fault_code_next == bfm_pkg::F_TIMEOUT) ||
                        (fault_code_next == bfm_pkg::F_HIGH);
  end

  always_comb begin
    if (!confirmed_flag_next) begin
      sev = bfm_pkg::SEV_NONE;
    end else if ((fault_code_next == bfm_pkg::F_STUCK) ||
                 (fault_code_next == bfm_pkg::F_MISMATCH)) begin
      sev = bfm_pkg::SEV_DEGRADED;
    end else begin
      sev = bfm_pkg::SEV_FAILSAFE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_code     <= bfm_pkg::F_NONE;
      fault_start    <= 32'd0;
      confirmed_flag <= 1'b0;
      recovery_start <= 32'd0;
      latched_flag   <= 1'b0;
      history_valid  <= 1'b0;
      for (int k = 0; k < bfm_pkg::WHEELS; k++) begin
        prior_wheels[k] <= 16'd0;
      end
    end else if (s1_go) begin
      fault_code     <= fault_code_next;
      fault_start    <= fault_start_next;
      confirmed_flag <= confirmed_flag_next;
      recovery_start <= recovery_start_next;
      latched_flag   <= latched_flag_next;
      // wheel history follows every sample that carries a message
      if (s1.has_message) begin
        history_valid   <= 1'b1;
        prior_wheels[0] <= s1.wheel0_kph;
        prior_wheels[1] <= s1.wheel1_kph;
        prior_wheels[2] <= s1.wheel2_kph;
        prior_wheels[3] <= s1.wheel3_kph;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res.active_fault    <= fault_code_next;
      res.fault_confirmed <= confirmed_flag_next;
      res.fault_latched   <= latched_flag_next;
      res.severity_level  <= sev;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res;

endmodule
`default_nettype wire
